// File: sv/id3cae_pkg.sv
// Shared types, constants and helpers for the ID3v2 cover picture extractor.
// No dependencies.
package id3cae_pkg;

   localparam int MAX_MIME_CHARS_DEF = 63;
   localparam int DESC_ZERO_RUN      = 3;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TAG_SIZE      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PICTURE_BYTES = 1'd1;

   localparam logic [23:0] MAX_TAG_SIZE_RST      = 24'd10485760;
   localparam logic [15:0] MIN_PICTURE_BYTES_RST = 16'd100;

   localparam logic [31:0] APIC_ID = 32'h41504943;

   localparam logic [2:0] ST_PIC_BYTE  = 3'd0;
   localparam logic [2:0] ST_PIC_LAST  = 3'd1;
   localparam logic [2:0] ST_NO_ID3    = 3'd2;
   localparam logic [2:0] ST_BAD_TAG   = 3'd3;
   localparam logic [2:0] ST_NO_APIC   = 3'd4;
   localparam logic [2:0] ST_TOO_SMALL = 3'd5;
   localparam logic [2:0] ST_TRUNCATED = 3'd6;

   typedef enum logic [8:0] {
      PH_HEADER    = 9'b000000001,
      PH_FRAME_HDR = 9'b000000010,
      PH_SKIP      = 9'b000000100,
      PH_ENC       = 9'b000001000,
      PH_MIME      = 9'b000010000,
      PH_PTYPE     = 9'b000100000,
      PH_DESC      = 9'b001000000,
      PH_PIC       = 9'b010000000,
      PH_DONE      = 9'b100000000
   } phase_type;

   // synchsafe value of a 32-bit word, top bits of each byte not masked
   function automatic logic [28:0] synch_value(input logic [31:0] w);
      synch_value = {w[31:24], 21'd0} | {7'd0, w[23:16], 14'd0}
                  | {14'd0, w[15:8], 7'd0} | {21'd0, w[7:0]};
   endfunction

   function automatic logic [7:0] magic_byte(input logic [1:0] k);
      case (k)
         2'd0:    magic_byte = 8'h49;
         2'd1:    magic_byte = 8'h44;
         default: magic_byte = 8'h33;
      endcase
   endfunction

endpackage

// File: sv/id3v2_cover_art_extractor.sv
// ID3v2 cover picture extractor: one file byte per item in, picture bytes and status out.
// Input and output are registered; 1 item per cycle while the output is not stalled,
// set by the single registered parse step. Synchronous active-high reset returns the
// parser to the header phase and the registers to their defaults. Depends on id3cae_pkg.
module id3v2_cover_art_extractor #(
   parameter int MAX_MIME_CHARS = id3cae_pkg::MAX_MIME_CHARS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_start_of_file,
   input  logic                               req_end_of_file,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_pic_byte,
   output logic                               rsp_is_last,
   output logic                               rsp_found,
   output logic [2:0]                         rsp_status,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [id3cae_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [id3cae_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import id3cae_pkg::*;

   localparam int MIME_W = $clog2(MAX_MIME_CHARS + 1);

   logic [23:0] max_tag_ff;
   logic [15:0] min_pic_ff;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        in_sof_ff, in_eof_ff;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        out_found_ff, out_found_in;
   logic [2:0]  out_status_ff, out_status_in;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [3:0]  hcnt_ff, hcnt_in, cur_hcnt;
   logic [23:0] tag_len_ff, tag_len_in, cur_tag_len;
   logic [23:0] tag_pos_ff, tag_pos_in, cur_tag_pos;
   logic [31:0] name_ff, name_in, cur_name;
   logic [31:0] fsb_ff, fsb_in, cur_fsb;
   logic [23:0] frm_len_ff, frm_len_in, cur_frm_len;
   logic [23:0] frm_off_ff, frm_off_in, cur_frm_off;
   logic [MIME_W-1:0] mime_ff, mime_in, cur_mime;
   logic [1:0]  zrun_ff, zrun_in, cur_zrun;
   logic        bad_ff, bad_in, cur_bad;

   logic        out_free, fire;
   logic [28:0] hdr_sz;
   logic [23:0] room;
   logic [31:0] frm_sz;
   logic        frm_end;
   logic [23:0] pic_rem;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !fire);

   assign cur_phase   = in_sof_ff ? PH_HEADER : phase_ff;
   assign cur_hcnt    = in_sof_ff ? 4'd0 : hcnt_ff;
   assign cur_tag_len = in_sof_ff ? 24'd0 : tag_len_ff;
   assign cur_tag_pos = in_sof_ff ? 24'd0 : tag_pos_ff;
   assign cur_name    = in_sof_ff ? 32'd0 : name_ff;
   assign cur_fsb     = in_sof_ff ? 32'd0 : fsb_ff;
   assign cur_frm_len = in_sof_ff ? 24'd0 : frm_len_ff;
   assign cur_frm_off = in_sof_ff ? 24'd0 : frm_off_ff;
   assign cur_mime    = in_sof_ff ? '0 : mime_ff;
   assign cur_zrun    = in_sof_ff ? 2'd0 : zrun_ff;
   assign cur_bad     = in_sof_ff ? 1'b0 : bad_ff;

   always_comb begin
      phase_in   = cur_phase;
      hcnt_in    = cur_hcnt;
      tag_len_in = cur_tag_len;
      tag_pos_in = cur_tag_pos;
      name_in    = cur_name;
      fsb_in     = cur_fsb;
      frm_len_in = cur_frm_len;
      frm_off_in = cur_frm_off;
      mime_in    = cur_mime;
      zrun_in    = cur_zrun;
      bad_in     = cur_bad;

      out_valid_in  = 1'b0;
      out_byte_in   = 8'd0;
      out_last_in   = 1'b0;
      out_found_in  = 1'b0;
      out_status_in = ST_PIC_BYTE;

      hdr_sz  = '0;
      room    = cur_tag_len - (cur_tag_pos + 24'd1);
      frm_sz  = cur_fsb;
      frm_end = 1'b0;
      pic_rem = '0;

      if (in_eof_ff) begin
         if (cur_phase != PH_DONE) begin
            out_valid_in  = 1'b1;
            out_last_in   = 1'b1;
            out_status_in = ST_TRUNCATED;
            phase_in      = PH_DONE;
         end
      end else begin
         unique case (cur_phase) inside
            PH_HEADER: begin
               if (cur_hcnt < 4'd3 && in_data_ff != magic_byte(cur_hcnt[1:0])) begin
                  bad_in = 1'b1;
               end
               if (cur_hcnt >= 4'd6) begin
                  fsb_in = {cur_fsb[23:0], in_data_ff};
               end
               hcnt_in = cur_hcnt + 4'd1;
               if (cur_hcnt >= 4'd9) begin
                  hdr_sz     = synch_value(fsb_in);
                  tag_len_in = hdr_sz[23:0];
                  tag_pos_in = 24'd0;
                  hcnt_in    = 4'd0;
                  fsb_in     = 32'd0;
                  name_in    = 32'd0;
                  phase_in   = PH_FRAME_HDR;
                  out_valid_in = 1'b1;
                  out_last_in  = 1'b1;
                  if (bad_in) begin
                     out_status_in = ST_NO_ID3;
                     phase_in      = PH_DONE;
                  end else if (hdr_sz == 29'd0 || hdr_sz > {5'd0, max_tag_ff}) begin
                     out_status_in = ST_BAD_TAG;
                     phase_in      = PH_DONE;
                  end else if (hdr_sz < 29'd10) begin
                     out_status_in = ST_NO_APIC;
                     phase_in      = PH_DONE;
                  end else begin
                     out_valid_in = 1'b0;
                     out_last_in  = 1'b0;
                  end
               end
            end

            PH_FRAME_HDR: begin
               tag_pos_in = cur_tag_pos + 24'd1;
               if (cur_hcnt < 4'd4) begin
                  name_in = {cur_name[23:0], in_data_ff};
               end else if (cur_hcnt < 4'd8) begin
                  fsb_in = {cur_fsb[23:0], in_data_ff};
               end
               hcnt_in = cur_hcnt + 4'd1;
               if (cur_hcnt >= 4'd9) begin
                  hcnt_in = 4'd0;
                  if (cur_fsb > {8'd0, room}) begin
                     frm_sz = {3'd0, synch_value(cur_fsb)};
                  end
                  if (frm_sz == 32'd0 || frm_sz > {8'd0, room}) begin
                     out_valid_in  = 1'b1;
                     out_last_in   = 1'b1;
                     out_status_in = ST_NO_APIC;
                     phase_in      = PH_DONE;
                  end else begin
                     frm_len_in = frm_sz[23:0];
                     frm_off_in = 24'd0;
                     mime_in    = '0;
                     zrun_in    = 2'd0;
                     phase_in   = (cur_name == APIC_ID) ? PH_ENC : PH_SKIP;
                  end
               end
            end

            PH_SKIP, PH_ENC, PH_MIME, PH_PTYPE, PH_DESC, PH_PIC: begin
               tag_pos_in = cur_tag_pos + 24'd1;
               frm_off_in = cur_frm_off + 24'd1;
               frm_end    = frm_off_in >= cur_frm_len;
               unique case (cur_phase)
                  PH_SKIP: begin
                     if (frm_end) begin
                        if ({1'b0, tag_pos_in} + 25'd10 > {1'b0, cur_tag_len}) begin
                           out_valid_in  = 1'b1;
                           out_last_in   = 1'b1;
                           out_status_in = ST_NO_APIC;
                           phase_in      = PH_DONE;
                        end else begin
                           name_in  = 32'd0;
                           fsb_in   = 32'd0;
                           phase_in = PH_FRAME_HDR;
                        end
                     end
                  end
                  PH_ENC: begin
                     phase_in = PH_MIME;
                     if (frm_end) begin
                        out_valid_in  = 1'b1;
                        out_last_in   = 1'b1;
                        out_status_in = ST_NO_APIC;
                        phase_in      = PH_DONE;
                     end
                  end
                  PH_MIME: begin
                     if (in_data_ff != 8'd0 && cur_mime < MIME_W'(MAX_MIME_CHARS)) begin
                        mime_in = cur_mime + 1'b1;
                     end else begin
                        phase_in = PH_PTYPE;
                     end
                     if (frm_end) begin
                        out_valid_in  = 1'b1;
                        out_last_in   = 1'b1;
                        out_status_in = ST_NO_APIC;
                        phase_in      = PH_DONE;
                     end
                  end
                  PH_PTYPE: begin
                     phase_in = PH_DESC;
                     if (frm_end) begin
                        out_valid_in  = 1'b1;
                        out_last_in   = 1'b1;
                        out_status_in = ST_TOO_SMALL;
                        phase_in      = PH_DONE;
                     end
                  end
                  PH_DESC: begin
                     zrun_in = (in_data_ff == 8'd0) ? cur_zrun + 2'd1 : 2'd0;
                     pic_rem = cur_frm_len - frm_off_in;
                     if (zrun_in >= 2'(DESC_ZERO_RUN)) begin
                        if (pic_rem > {8'd0, min_pic_ff}) begin
                           phase_in = PH_PIC;
                        end else begin
                           out_valid_in  = 1'b1;
                           out_last_in   = 1'b1;
                           out_status_in = ST_TOO_SMALL;
                           phase_in      = PH_DONE;
                        end
                     end else if (frm_end) begin
                        out_valid_in  = 1'b1;
                        out_last_in   = 1'b1;
                        out_status_in = ST_TOO_SMALL;
                        phase_in      = PH_DONE;
                     end
                  end
                  default: begin
                     out_valid_in = 1'b1;
                     out_byte_in  = in_data_ff;
                     if (frm_end) begin
                        out_last_in   = 1'b1;
                        out_found_in  = 1'b1;
                        out_status_in = ST_PIC_LAST;
                        phase_in      = PH_DONE;
                     end
                  end
               endcase
            end

            default: begin
               phase_in = cur_phase;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_tag_ff <= MAX_TAG_SIZE_RST;
         min_pic_ff <= MIN_PICTURE_BYTES_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_TAG_SIZE:      max_tag_ff <= csr_wdata[23:0];
            CSR_MIN_PICTURE_BYTES: min_pic_ff <= csr_wdata[15:0];
            default:               max_tag_ff <= max_tag_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data_byte;
         in_sof_ff  <= req_start_of_file;
         in_eof_ff  <= req_end_of_file;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hcnt_ff    <= 4'd0;
         tag_len_ff <= 24'd0;
         tag_pos_ff <= 24'd0;
         name_ff    <= 32'd0;
         fsb_ff     <= 32'd0;
         frm_len_ff <= 24'd0;
         frm_off_ff <= 24'd0;
         mime_ff    <= '0;
         zrun_ff    <= 2'd0;
         bad_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         hcnt_ff    <= hcnt_in;
         tag_len_ff <= tag_len_in;
         tag_pos_ff <= tag_pos_in;
         name_ff    <= name_in;
         fsb_ff     <= fsb_in;
         frm_len_ff <= frm_len_in;
         frm_off_ff <= frm_off_in;
         mime_ff    <= mime_in;
         zrun_ff    <= zrun_in;
         bad_ff     <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= fire && out_valid_in;
      end
      if (fire && out_valid_in) begin
         out_byte_ff   <= out_byte_in;
         out_last_ff   <= out_last_in;
         out_found_ff  <= out_found_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_pic_byte = out_byte_ff;
   assign rsp_is_last  = out_last_ff;
   assign rsp_found    = out_found_ff;
   assign rsp_status   = out_status_ff;

   a_found_is_success: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_is_last && rsp_status == ST_PIC_LAST)
      else $error("found without a successful last item");

   a_not_last_is_pic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |-> rsp_status == ST_PIC_BYTE && !rsp_found)
      else $error("non-final item with a final status");

   a_silent_after_done: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_DONE && !in_sof_ff |=> !rsp_valid)
      else $error("item emitted after the final item of a file");

endmodule
